>>> design/tvpu_pkg.sv
package tvpu_pkg;

   // Field widths fixed by the packet and frame-buffer formats.
   localparam int WORD_W    = 16;
   localparam int ADDR_W    = 15;
   localparam int COL_OUT_W = 8;
   localparam int ROW_OUT_W = 7;
   localparam int LINE_W    = 6;
   localparam int SEG_W     = 3;
   localparam int STATUS_W  = 3;

   // ID word checks.
   localparam logic [3:0]        DISCARD_NIBBLE     = 4'hF;
   localparam logic [LINE_W-1:0] SEGMENT_CHECK_LINE = 6'd20;

   // Tracking reset values.
   localparam logic [WORD_W-1:0] MAX_CLEAR_VALUE = 16'h0000;
   localparam logic [WORD_W-1:0] MIN_CLEAR_VALUE = 16'hFFFF;

   // Result queue depth; it must hold at least two entries.
   localparam int RSP_FIFO_DEPTH = 4;

   // Result kinds.
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Where the receiver stands inside a packet.
   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_CRC,
      PHASE_PIXEL
   } phase_type;

   // Packet status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_DISCARD      = 3'd1,
      STATUS_LINE_MISMATCH = 3'd2,
      STATUS_SEG_ZERO     = 3'd3,
      STATUS_SEG_MISMATCH = 3'd4,
      STATUS_ZERO_PIXEL   = 3'd5
   } status_type;

   // One result as it waits in the queue.
   typedef struct packed {
      logic                 kind;
      logic                 last;
      logic [ADDR_W-1:0]    pixel_addr;
      logic [WORD_W-1:0]    pixel_value;
      status_type           status;
      logic [WORD_W-1:0]    max_value;
      logic [COL_OUT_W-1:0] max_col;
      logic [ROW_OUT_W-1:0] max_row;
      logic [WORD_W-1:0]    min_value;
      logic [COL_OUT_W-1:0] min_col;
      logic [ROW_OUT_W-1:0] min_row;
   } rsp_entry_type;

endpackage

>>> design/tvpu_rsp_fifo.sv
module tvpu_rsp_fifo
   import tvpu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en0,
   input  rsp_entry_type wr_data0,
   input  logic          wr_en1,
   input  rsp_entry_type wr_data1,
   output logic          has_room_for_two,
   output logic          rd_valid,
   input  logic          rd_stall,
   output rsp_entry_type rd_data
);

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_entry_type      mem_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic [CNT_W-1:0]   push_count;
   logic               pop;

   // Status of the queue toward both sides.
   assign rd_valid         = (count_ff != '0);
   assign rd_data          = mem_ff[rd_ptr_ff];
   assign has_room_for_two = (count_ff <= CNT_W'(RSP_FIFO_DEPTH - 2));
   assign pop              = rd_valid & ~rd_stall;

   // Pointer and fill count updates; the second write always follows the first.
   always_comb begin
      wr_ptr_next = wr_ptr_ff + PTR_W'(1);
      push_count  = CNT_W'(wr_en0) + CNT_W'(wr_en1);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      count_in    = count_ff + push_count - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr_en0) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_en1) begin
         mem_ff[wr_ptr_next] <= wr_data1;
      end
   end

endmodule

>>> design/thermal_video_packet_unpacker_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   packet word, first-word flag, frame clear,
//                                            expected line and segment
// rsp_      out        rsp_valid/rsp_stall   pixel write or packet status, with the
//                                            frame's max/min tracking
//
// Each word is captured in an input register, decoded there, and its
// zero, one or two results are written into a four-entry result queue.
// A word is accepted every cycle while the queue has room for two results; the
// last pixel of a packet writes two results, so only a stalled output slows input.
// An accepted word's results pass through the input register and then the result queue.
// The row base address is multiplied out during the CRC word.
// Reset is synchronous and empties the input register and the queue.
module thermal_video_packet_unpacker_top
   import tvpu_pkg::*;
#(
   parameter int PACKET_PIXELS    = 80,
   parameter int FRAME_WIDTH      = 160,
   parameter int ROWS_PER_SEGMENT = 30
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_packet_word,
   input  logic                 req_first_word,
   input  logic                 req_new_frame,
   input  logic [LINE_W-1:0]    req_expected_line,
   input  logic [SEG_W-1:0]     req_expected_segment,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic                 rsp_last,
   output logic [ADDR_W-1:0]    rsp_pixel_addr,
   output logic [WORD_W-1:0]    rsp_pixel_value,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [WORD_W-1:0]    rsp_max_value,
   output logic [COL_OUT_W-1:0] rsp_max_col,
   output logic [ROW_OUT_W-1:0] rsp_max_row,
   output logic [WORD_W-1:0]    rsp_min_value,
   output logic [COL_OUT_W-1:0] rsp_min_col,
   output logic [ROW_OUT_W-1:0] rsp_min_row
);

   localparam int COL_W  = (PACKET_PIXELS > 1) ? $clog2(PACKET_PIXELS) : 1;
   localparam int X_W    = $clog2(2 * PACKET_PIXELS);
   localparam int ROW_W  = $clog2(8 * ROWS_PER_SEGMENT + 32);
   localparam int FW_W   = $clog2(FRAME_WIDTH + 1);
   localparam int PROD_W = (ROW_W + FW_W > ADDR_W) ? (ROW_W + FW_W) : ADDR_W;

   // Input register.
   logic                 s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0]    s1_word_ff;
   logic                 s1_first_ff;
   logic                 s1_new_frame_ff;
   logic [LINE_W-1:0]    s1_line_ff;
   logic [SEG_W-1:0]     s1_seg_ff;
   logic                 req_take;
   logic                 advance;

   // Packet state.
   phase_type            phase_ff, phase_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [X_W-1:0]       x_ff, x_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_W-1:0]    row_base_ff, row_base_in;

   // Frame tracking state.
   logic [WORD_W-1:0]    max_value_ff, max_value_in;
   logic [COL_OUT_W-1:0] max_col_ff, max_col_in;
   logic [ROW_OUT_W-1:0] max_row_ff, max_row_in;
   logic [WORD_W-1:0]    min_value_ff, min_value_in;
   logic [COL_OUT_W-1:0] min_col_ff, min_col_in;
   logic [ROW_OUT_W-1:0] min_row_ff, min_row_in;

   // Decode.
   status_type           id_status;
   logic [3:0]           id_segment;
   logic                 col_last;
   logic                 zero_pixel;
   logic [SEG_W-1:0]     seg_m1;
   logic [PROD_W-1:0]    row_prod;
   logic [ADDR_W-1:0]    pixel_addr;
   logic                 push0, push1;
   rsp_entry_type        entry0, entry1, head;
   logic                 has_room;

   // Input handshake: the held word moves on when the queue can take two results.
   assign advance     = s1_valid_ff & has_room;
   assign req_stall   = s1_valid_ff & ~advance;
   assign req_take    = req_valid & ~req_stall;
   assign s1_valid_in = req_take | (s1_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff      <= req_packet_word;
         s1_first_ff     <= req_first_word;
         s1_new_frame_ff <= req_new_frame;
         s1_line_ff      <= req_expected_line;
         s1_seg_ff       <= req_expected_segment;
      end
   end

   // ID word check: discard, then line, then segment on the check line.
   always_comb begin
      id_segment = s1_word_ff[15:12];
      id_status  = STATUS_OK;
      if (s1_word_ff[11:8] == DISCARD_NIBBLE) begin
         id_status = STATUS_DISCARD;
      end else if (s1_word_ff[7:0] != {2'b00, s1_line_ff}) begin
         id_status = STATUS_LINE_MISMATCH;
      end else if (s1_line_ff == SEGMENT_CHECK_LINE) begin
         if (id_segment == 4'd0) begin
            id_status = STATUS_SEG_ZERO;
         end else if (id_segment != {1'b0, s1_seg_ff}) begin
            id_status = STATUS_SEG_MISMATCH;
         end
      end
   end

   assign col_last   = (col_ff == COL_W'(PACKET_PIXELS - 1));
   assign zero_pixel = (s1_word_ff == '0);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         if (s1_first_ff) begin
            phase_in = (id_status == STATUS_OK) ? PHASE_CRC : PHASE_IDLE;
         end else begin
            case (phase_ff)
               PHASE_IDLE:  phase_in = PHASE_IDLE;
               PHASE_CRC:   phase_in = PHASE_PIXEL;
               PHASE_PIXEL: phase_in = (zero_pixel | col_last) ? PHASE_IDLE : PHASE_PIXEL;
               default:     phase_in = PHASE_IDLE;
            endcase
         end
      end
   end

   // Row and address arithmetic.
   always_comb begin
      seg_m1      = s1_seg_ff - SEG_W'(1);
      row_prod    = PROD_W'(row_ff) * PROD_W'(FRAME_WIDTH);
      row_base_in = row_prod[ADDR_W-1:0];
      row_in      = ROW_W'(ROW_W'(seg_m1) * ROW_W'(ROWS_PER_SEGMENT))
                    + ROW_W'(s1_line_ff[LINE_W-1:1]);
      pixel_addr  = row_base_ff + ADDR_W'(x_ff);
   end

   // Tracking update, counters and result writes.
   always_comb begin
      max_value_in = s1_new_frame_ff ? MAX_CLEAR_VALUE : max_value_ff;
      max_col_in   = s1_new_frame_ff ? '0 : max_col_ff;
      max_row_in   = s1_new_frame_ff ? '0 : max_row_ff;
      min_value_in = s1_new_frame_ff ? MIN_CLEAR_VALUE : min_value_ff;
      min_col_in   = s1_new_frame_ff ? '0 : min_col_ff;
      min_row_in   = s1_new_frame_ff ? '0 : min_row_ff;
      col_in       = col_ff;
      x_in         = x_ff;
      push0        = 1'b0;
      push1        = 1'b0;

      entry0             = '0;
      entry0.kind        = KIND_STATUS;
      entry0.last        = 1'b1;
      entry0.status      = STATUS_OK;

      if (s1_first_ff) begin
         col_in = '0;
         x_in   = s1_line_ff[0] ? X_W'(PACKET_PIXELS) : '0;
         if (id_status != STATUS_OK) begin
            push0         = 1'b1;
            entry0.status = id_status;
         end
      end else if (phase_ff == PHASE_PIXEL) begin
         if (s1_word_ff > max_value_in) begin
            max_value_in = s1_word_ff;
            max_col_in   = COL_OUT_W'(x_ff);
            max_row_in   = ROW_OUT_W'(row_ff);
         end
         if (s1_word_ff < min_value_in) begin
            min_value_in = s1_word_ff;
            min_col_in   = COL_OUT_W'(x_ff);
            min_row_in   = ROW_OUT_W'(row_ff);
         end
         push0 = 1'b1;
         if (zero_pixel) begin
            entry0.status = STATUS_ZERO_PIXEL;
         end else begin
            entry0.kind        = KIND_PIXEL;
            entry0.last        = ~col_last;
            entry0.pixel_addr  = pixel_addr;
            entry0.pixel_value = s1_word_ff;
            push1              = col_last;
            col_in             = col_ff + COL_W'(1);
            x_in               = x_ff + X_W'(1);
         end
      end

      entry0.max_value = max_value_in;
      entry0.max_col   = max_col_in;
      entry0.max_row   = max_row_in;
      entry0.min_value = min_value_in;
      entry0.min_col   = min_col_in;
      entry0.min_row   = min_row_in;

      // The closing status of a complete packet.
      entry1             = entry0;
      entry1.kind        = KIND_STATUS;
      entry1.last        = 1'b1;
      entry1.pixel_addr  = '0;
      entry1.pixel_value = '0;
      entry1.status      = STATUS_OK;
   end

   // Control and tracking registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         max_value_ff <= MAX_CLEAR_VALUE;
         max_col_ff   <= '0;
         max_row_ff   <= '0;
         min_value_ff <= MIN_CLEAR_VALUE;
         min_col_ff   <= '0;
         min_row_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (advance) begin
            max_value_ff <= max_value_in;
            max_col_ff   <= max_col_in;
            max_row_ff   <= max_row_in;
            min_value_ff <= min_value_in;
            min_col_ff   <= min_col_in;
            min_row_ff   <= min_row_in;
         end
      end
   end

   // Position registers; the packet's row is latched at the ID word.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         x_ff        <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         x_ff   <= x_in;
         if (s1_first_ff) begin
            row_ff <= row_in;
         end else if (phase_ff == PHASE_CRC) begin
            row_base_ff <= row_base_in;
         end
      end
   end

   // Result queue.
   tvpu_rsp_fifo u_rsp_fifo (
      .clock            (clock),
      .reset            (reset),
      .wr_en0           (advance & push0),
      .wr_data0         (entry0),
      .wr_en1           (advance & push1),
      .wr_data1         (entry1),
      .has_room_for_two (has_room),
      .rd_valid         (rsp_valid),
      .rd_stall         (rsp_stall),
      .rd_data          (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_last        = head.last;
   assign rsp_pixel_addr  = head.pixel_addr;
   assign rsp_pixel_value = head.pixel_value;
   assign rsp_status      = head.status;
   assign rsp_max_value   = head.max_value;
   assign rsp_max_col     = head.max_col;
   assign rsp_max_row     = head.max_row;
   assign rsp_min_value   = head.min_value;
   assign rsp_min_col     = head.min_col;
   assign rsp_min_row     = head.min_row;

   // A second result is only written together with a first one.
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> (push0 & ~zero_pixel & col_last))
      else $error("second result without a completed packet");

   // The final pixel of a packet always returns the receiver to idle.
   a_packet_end: assert property (@(posedge clock) disable iff (reset)
      (advance & ~s1_first_ff & (phase_ff == PHASE_PIXEL) & col_last) |=>
      (phase_ff == PHASE_IDLE))
      else $error("packet did not end after its last pixel");

   // The column counter stays inside the packet while pixels are expected.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_PIXEL) |-> (col_ff <= COL_W'(PACKET_PIXELS - 1)))
      else $error("pixel column beyond packet length");

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> ~rsp_valid)
      else $error("result queue not empty after reset");

endmodule
